>>> sv/b64d_pkg.sv
// Shared types, result codes and the character classifier of the Base64 stream decoder.
// No dependencies.
package b64d_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd65;

  localparam int FIFO_DEPTH_DEFAULT = 4;

  // One queued command: up to three decoded bytes, then an optional error or done result.
  typedef struct packed {
    logic [1:0]       nbytes;
    logic             has_tail;
    logic [1:0]       tail_kind;
    logic [15:0]      tail_value;
    logic [2:0][7:0]  data;
  } cmd_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] v;
    v = SEXTET_BAD;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = 7'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = 7'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 7'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      v = 7'd62;
    end else if (ch == 8'h2F) begin
      v = 7'd63;
    end else if (ch == 8'h3D) begin
      v = SEXTET_PAD;
    end
    return v;
  endfunction

endpackage

>>> sv/b64d_front.sv
// Front end: accepts characters, classifies them and tracks group and message state.
// Pushes one command per character that causes results. Depends on b64d_pkg.
module b64d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // char_in
  input  logic              s_tlast,   // msg_last
  input  logic              fifo_full,
  output logic              push,
  output b64d_pkg::cmd_t    push_cmd
);
  import b64d_pkg::*;

  logic [1:0]  group_phase, group_phase_next;
  logic [17:0] held_sextets, held_sextets_next;
  logic        third_was_pad, third_was_pad_next;
  logic [15:0] char_index, char_index_next;
  logic [15:0] bytes_out, bytes_out_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic [6:0]  v;
  logic        is_bad;
  logic [1:0]  nb;
  logic [5:0]  sa, sb, sc;

  assign s_tready = !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign v        = sextet_of(s_tdata);
  assign is_bad   = (v == SEXTET_BAD) || ((v == SEXTET_PAD) && (group_phase < 2'd2));
  assign sa       = held_sextets[17:12];
  assign sb       = held_sextets[11:6];
  assign sc       = held_sextets[5:0];

  always_comb begin
    group_phase_next   = group_phase;
    held_sextets_next  = held_sextets;
    third_was_pad_next = third_was_pad;
    char_index_next    = char_index;
    bytes_out_next     = bytes_out;
    discarding_next    = discarding;
    nb                 = 2'd0;
    push               = 1'b0;
    push_cmd           = '0;
    push_cmd.data[0]   = {sa, sb[5:4]};
    push_cmd.data[1]   = {sb[3:0], sc[5:2]};
    push_cmd.data[2]   = {sc[1:0], v[5:0]};
    if (accept) begin
      if (discarding) begin
        if (s_tlast) begin
          char_index_next = '0;
          bytes_out_next  = '0;
          discarding_next = 1'b0;
        end else begin
          char_index_next = char_index + 16'd1;
        end
      end else if (is_bad) begin
        push                = 1'b1;
        push_cmd.has_tail   = 1'b1;
        push_cmd.tail_kind  = KIND_ERROR;
        push_cmd.tail_value = char_index;
        group_phase_next    = '0;
        held_sextets_next   = '0;
        third_was_pad_next  = 1'b0;
        if (s_tlast) begin
          char_index_next = '0;
          bytes_out_next  = '0;
        end else begin
          discarding_next = 1'b1;
          char_index_next = char_index + 16'd1;
        end
      end else begin
        case (group_phase)
          2'd0, 2'd1: begin
            held_sextets_next = {held_sextets[11:0], v[5:0]};
            group_phase_next  = group_phase + 2'd1;
          end
          2'd2: begin
            held_sextets_next = {held_sextets[11:0], v[5:0]};
            if (v == SEXTET_PAD) begin
              third_was_pad_next = 1'b1;
            end
            group_phase_next = 2'd3;
          end
          default: begin
            if (third_was_pad) begin
              nb = 2'd1;
            end else if (v == SEXTET_PAD) begin
              nb = 2'd2;
            end else begin
              nb = 2'd3;
            end
            group_phase_next   = '0;
            held_sextets_next  = '0;
            third_was_pad_next = 1'b0;
          end
        endcase
        bytes_out_next  = bytes_out + 16'(nb);
        char_index_next = char_index + 16'd1;
        push_cmd.nbytes = nb;
        if (s_tlast) begin
          push_cmd.has_tail = 1'b1;
          if (group_phase_next != 2'd0) begin
            push_cmd.tail_kind  = KIND_ERROR;
            push_cmd.tail_value = char_index_next;
          end else begin
            push_cmd.tail_kind  = KIND_DONE;
            push_cmd.tail_value = bytes_out_next;
          end
          group_phase_next   = '0;
          held_sextets_next  = '0;
          third_was_pad_next = 1'b0;
          char_index_next    = '0;
          bytes_out_next     = '0;
        end
        push = (nb != 2'd0) || s_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= '0;
      held_sextets  <= '0;
      third_was_pad <= 1'b0;
      char_index    <= '0;
      bytes_out     <= '0;
      discarding    <= 1'b0;
    end else begin
      group_phase   <= group_phase_next;
      held_sextets  <= held_sextets_next;
      third_was_pad <= third_was_pad_next;
      char_index    <= char_index_next;
      bytes_out     <= bytes_out_next;
      discarding    <= discarding_next;
    end
  end

endmodule

>>> sv/b64d_fifo.sv
// Short command queue between the front end and the back end.
// Depends on b64d_pkg.
module b64d_fifo #(
  parameter int DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64d_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output b64d_pkg::cmd_t    head
);
  import b64d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> sv/b64d_back.sv
// Back end: expands each queued command into result beats in an output register.
// Depends on b64d_pkg.
module b64d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  b64d_pkg::cmd_t    head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // data_byte, error_index, byte_count
  output logic [1:0]        m_tuser,   // kind
  output logic              m_tlast    // run_last
);
  import b64d_pkg::*;

  logic [1:0]  pos;
  logic [2:0]  n_res;
  logic        res_last;
  logic        load;
  logic        is_byte;
  logic [39:0] tdata_next;
  logic [1:0]  kind_next;

  assign n_res    = {1'b0, head.nbytes} + {2'b00, head.has_tail};
  assign res_last = ({1'b0, pos} + 3'd1) == n_res;
  assign load     = !empty && (!m_tvalid || m_tready);
  assign pop      = load && res_last;
  assign is_byte  = pos < head.nbytes;

  always_comb begin
    tdata_next = '0;
    kind_next  = head.tail_kind;
    if (is_byte) begin
      kind_next        = KIND_BYTE;
      tdata_next[7:0]  = head.data[pos];
    end else if (head.tail_kind == KIND_ERROR) begin
      tdata_next[23:8] = head.tail_value;
    end else begin
      tdata_next[39:24] = head.tail_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        pos      <= res_last ? 2'd0 : pos + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= tdata_next;
      m_tuser <= kind_next;
      m_tlast <= res_last;
    end
  end

  a_tail_is_last: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_DONE) |-> m_tlast)
    else $error("error or done result not marked last");
  a_pos_restart: assert property (@(posedge clk) disable iff (rst) pop |=> pos == 2'd0)
    else $error("result position not restarted after a command");
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> {1'b0, pos} < n_res)
    else $error("result position beyond the command");

endmodule

>>> sv/base64_stream_decoder.sv
// Base64 stream decoder: one character beat in, decoded byte, error or done beats out.
// Commands are registered in the command queue and result beats in the output register.
// One character is taken per cycle while the command queue has room; results leave one per
// cycle while m_tready is high, so a four-character group yields up to four result beats.
// Reset clears all message state, empties the command queue and clears the output valid.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
module base64_stream_decoder #(
  parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in
  input  logic        s_tlast,   // msg_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_byte, error_index, byte_count
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // run_last
);
  import b64d_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_cmd, head;

  b64d_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .fifo_full(full), .push(push), .push_cmd(push_cmd)
  );

  b64d_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  b64d_back u_back (
    .clk(clk), .rst(rst),
    .empty(empty), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of base64_stream_decoder: a scoreboard class predicts every
// result beat from the accepted characters; send_char drives characters, result_sink m_tready.
// Depends on b64d_pkg and the base64_stream_decoder RTL.
`timescale 1ns / 1ps

import b64d_pkg::*;

typedef struct packed {
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] error_index;
  logic [15:0] byte_count;
  logic        run_last;
} decode_result_t;

class decode_scoreboard;
  logic [1:0]     group_phase;
  logic [17:0]    held_sextets;
  logic           third_pad;
  logic [15:0]    char_index;
  logic [15:0]    bytes_out;
  logic           discarding;
  decode_result_t pending_results[$];
  int             errors;

  function new();
    errors = 0;
    clear_message();
  endfunction

  function void clear_group();
    group_phase  = 2'd0;
    held_sextets = 18'd0;
    third_pad    = 1'b0;
  endfunction

  function void clear_message();
    clear_group();
    char_index = 16'd0;
    bytes_out  = 16'd0;
    discarding = 1'b0;
  endfunction

  function logic [6:0] sextet_value(logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return 7'(ch - 8'h41);
    if (ch >= 8'h61 && ch <= 8'h7A) return 7'(ch - 8'h61 + 8'd26);
    if (ch >= 8'h30 && ch <= 8'h39) return 7'(ch - 8'h30 + 8'd52);
    if (ch == 8'h2B) return 7'd62;
    if (ch == 8'h2F) return 7'd63;
    if (ch == 8'h3D) return SEXTET_PAD;
    return SEXTET_BAD;
  endfunction

  function decode_result_t make_result(logic [1:0] kind, logic [7:0] data_byte,
                                       logic [15:0] error_index, logic [15:0] byte_count);
    decode_result_t r;
    r.kind        = kind;
    r.data_byte   = data_byte;
    r.error_index = error_index;
    r.byte_count  = byte_count;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function void note_char(logic [7:0] ch, logic last);
    decode_result_t beat_results[$];
    logic [6:0]     v;
    logic [5:0]     a;
    logic [5:0]     b;
    logic [5:0]     c;
    int             nbytes;
    nbytes = 0;
    if (discarding) begin
      if (last) begin
        clear_message();
      end else begin
        char_index++;
      end
      return;
    end
    v = sextet_value(ch);
    if (v == SEXTET_BAD || (v == SEXTET_PAD && group_phase < 2'd2)) begin
      beat_results.push_back(make_result(KIND_ERROR, 8'd0, char_index, 16'd0));
      if (last) begin
        clear_message();
      end else begin
        clear_group();
        discarding = 1'b1;
        char_index++;
      end
    end else begin
      if (group_phase < 2'd2) begin
        held_sextets = {held_sextets[11:0], v[5:0]};
        group_phase++;
      end else if (group_phase == 2'd2) begin
        if (v == SEXTET_PAD) begin
          third_pad    = 1'b1;
          held_sextets = {held_sextets[11:0], 6'd0};
        end else begin
          held_sextets = {held_sextets[11:0], v[5:0]};
        end
        group_phase = 2'd3;
      end else begin
        a = held_sextets[17:12];
        b = held_sextets[11:6];
        c = held_sextets[5:0];
        beat_results.push_back(make_result(KIND_BYTE, {a, b[5:4]}, 16'd0, 16'd0));
        nbytes = 1;
        if (!third_pad) begin
          beat_results.push_back(make_result(KIND_BYTE, {b[3:0], c[5:2]}, 16'd0, 16'd0));
          nbytes = 2;
          if (v != SEXTET_PAD) begin
            beat_results.push_back(make_result(KIND_BYTE, {c[1:0], v[5:0]}, 16'd0, 16'd0));
            nbytes = 3;
          end
        end
        clear_group();
      end
      bytes_out  = bytes_out + 16'(nbytes);
      char_index = char_index + 16'd1;
      if (last) begin
        if (group_phase != 2'd0) begin
          beat_results.push_back(make_result(KIND_ERROR, 8'd0, char_index, 16'd0));
        end else begin
          beat_results.push_back(make_result(KIND_DONE, 8'd0, 16'd0, bytes_out));
        end
        clear_message();
      end
    end
    if (beat_results.size() > 0) beat_results[beat_results.size() - 1].run_last = 1'b1;
    foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_field(string name, int got, int want);
    if (got != want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task check_result(decode_result_t got);
    decode_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result beat, kind %0d", got.kind));
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", got.kind, want.kind);
    check_field("data_byte", got.data_byte, want.data_byte);
    check_field("error_index", got.error_index, want.error_index);
    check_field("byte_count", got.byte_count, want.byte_count);
    check_field("run_last", got.run_last, want.run_last);
  endtask
endclass

module tb_top;

  localparam int STALL_LIMIT    = 1000;
  localparam int RANDOM_CHARS   = 220;
  localparam int DRAIN_CYCLES   = 20;
  localparam int IDLE_PERCENT   = 29;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  bit               steady = 1'b0;
  char_beat_t       char_beats[$];
  decode_scoreboard decoder_sb = new();

  base64_stream_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  function automatic logic [7:0] alphabet_char(int v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [7:0] random_alpha();
    return alphabet_char($urandom_range(0, 63));
  endfunction

  function automatic void add_char(logic [7:0] ch, logic last);
    char_beat_t cb;
    cb.ch   = ch;
    cb.last = last;
    char_beats.push_back(cb);
  endfunction

  function automatic void add_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) add_char(s[i], last && (i == s.len() - 1));
  endfunction

  // pads: 0 for a full group, 1 for a pad in fourth place, 2 for a pad in third and mostly fourth.
  function automatic void add_group(int pads, logic last);
    logic [7:0] fourth;
    add_char(random_alpha(), 1'b0);
    add_char(random_alpha(), 1'b0);
    add_char(pads == 2 ? 8'h3D : random_alpha(), 1'b0);
    if (pads == 0) begin
      fourth = random_alpha();
    end else if (pads == 2 && $urandom_range(0, 3) == 0) begin
      fourth = random_alpha();
    end else begin
      fourth = 8'h3D;
    end
    add_char(fourth, last);
  endfunction

  function automatic void add_wellformed();
    int ngroups;
    ngroups = $urandom_range(1, 4);
    for (int g = 0; g < ngroups - 1; g++) begin
      add_group(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, 1'b0);
    end
    add_group($urandom_range(0, 2), 1'b1);
  endfunction

  function automatic void build_stimulus();
    int start;
    int len;
    int pos;
    add_text("+/9v", 1'b1);
    add_text("Zg==Zm8=", 1'b1);
    add_text("Zg=A", 1'b1);
    add_text("=", 1'b1);
    add_text("Q=x", 1'b1);
    add_char(8'hFF, 1'b0);
    add_char(8'h00, 1'b1);
    add_text("Zm9", 1'b1);
    while (char_beats.size() < RANDOM_CHARS) begin
      start = char_beats.size();
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)), i == len - 1);
        end
        1: begin
          len = $urandom_range(1, 11);
          if (len % 4 == 0) len++;
          for (int i = 0; i < len; i++) add_char(random_alpha(), i == len - 1);
        end
        2: begin
          add_wellformed();
          pos = $urandom_range(start, char_beats.size() - 1);
          char_beats[pos].ch = 8'($urandom_range(0, 255));
        end
        default: begin
          add_wellformed();
        end
      endcase
    end
  endfunction

  task automatic send_char(logic [7:0] ch, logic last);
    while (take_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    decoder_sb.note_char(ch, last);
  endtask

  initial begin : result_sink
    decode_result_t got;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.data_byte   = m_tdata[7:0];
        got.error_index = m_tdata[23:8];
        got.byte_count  = m_tdata[39:24];
        got.run_last    = m_tlast;
        decoder_sb.check_result(got);
      end
      m_tready <= !take_gap();
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int n;
    build_stimulus();
    n = char_beats.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 2) && (i < n / 2 + 60);
      send_char(char_beats[i].ch, char_beats[i].last);
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;
    while (decoder_sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_fifo.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
tb/tb_top.sv
